FILE: rtl/core/dth_pkg.sv
// ============================================================================
// dth_pkg
// Shared types and constants for the depth to hue colour mapper.
// ============================================================================
`default_nettype none

package dth_pkg;

    localparam int DEPTH_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_HI   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_RECIP = 2'd2;

    localparam logic [31:0] DEPTH_LO_RST   = 32'd0;
    localparam logic [31:0] DEPTH_HI_RST   = 32'd65535;
    localparam logic [31:0] SPAN_RECIP_RST = 32'd65537;

    localparam logic [31:0] RGBA_WHITE = 32'hFFFF_FFFF;
    localparam logic [31:0] RGBA_BLACK = 32'hFF00_0000;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // channel levels times 255 over the level denominator, truncated
    localparam logic [7:0] LVL_V_BYTE = 8'd191;
    localparam logic [7:0] LVL_M_BYTE = 8'd63;

    // ramp levels in units of 1/40000, times 255
    localparam int LVL_W = 23;
    localparam logic [LVL_W-1:0] MID_SLOPE = 23'd5100255;   // 255 * 20001
    localparam logic [LVL_W-1:0] MID1_BASE = 23'd2550000;   // 255 * 10000
    localparam logic [LVL_W-1:0] MID2_BASE = 23'd7650000;   // 255 * 30000

    // divide by 40000: ceil(2^38 / 40000), exact for values below 2^23
    localparam int DIV_SHIFT = 38;
    localparam int DIV_W     = LVL_W + 23;
    localparam logic [22:0] DIV_RECIP = 23'd6871948;

    // hue sextants
    localparam logic [2:0] SEXT_0 = 3'd0;
    localparam logic [2:0] SEXT_1 = 3'd1;
    localparam logic [2:0] SEXT_2 = 3'd2;
    localparam logic [2:0] SEXT_3 = 3'd3;
    localparam logic [2:0] SEXT_4 = 3'd4;
    localparam logic [2:0] SEXT_5 = 3'd5;

    typedef struct packed {
        logic       last;
        logic       below;
        logic       black;
        logic [2:0] sext;
    } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/depth_to_hue_colour.sv
// ============================================================================
// depth_to_hue_colour
// Depth sample to RGBA hue ramp colour, seven stage pipeline.
// ============================================================================
// Usage:
//   s_tdata carries one depth sample per word, s_tlast the frame end flag.
//   m_tdata carries the packed colour (red low byte, alpha high byte),
//   m_tlast the copied frame end flag.
//   cfg_valid/cfg_index/cfg_data write the low depth bound (0), the high
//   depth bound (1) and the span reciprocal (2); other indexes are dropped.
//   cfg_ready is always high. Write configuration only while the pipeline
//   is empty.
// Timing:
//   One word is accepted every cycle while m_tready is high; the range
//   multiply, the ramp multiply and the divide-by-40000 reciprocal
//   multiply each own a stage.
// Reset:
//   rst_n clears all stage valid bits and loads the register defaults
//   (low bound 0, high bound 65535, reciprocal 65537).
// Stall:
//   Each stage holds while the stage after it is full and held, so empty
//   stages keep filling while m_tready is low; s_tready drops only once
//   every stage holds a word.
// ============================================================================
`default_nettype none

module depth_to_hue_colour #(
    parameter int DEPTH_BITS    = dth_pkg::DEPTH_BITS_DEF,
    parameter int FRACTION_BITS = dth_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dth_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [((DEPTH_BITS+7)/8)*8-1:0] s_tdata,  // [DEPTH_BITS-1:0] depth
    input  wire logic                          s_tlast,    // frame_end

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,    // [31:0] rgba
    output logic                               m_tlast     // frame_end_out
);

    localparam int F      = FRACTION_BITS;
    localparam int PROD_W = DEPTH_BITS + 32;
    localparam int NORM_W = DEPTH_BITS + F;
    localparam int Y_W    = F + dth_pkg::LVL_W;
    localparam int NS     = 7;

    // configuration registers
    logic [DEPTH_BITS-1:0] depth_lo_reg;
    logic [DEPTH_BITS-1:0] depth_hi_reg;
    logic [31:0]           span_recip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_lo_reg   <= DEPTH_BITS'(dth_pkg::DEPTH_LO_RST);
            depth_hi_reg   <= DEPTH_BITS'(dth_pkg::DEPTH_HI_RST);
            span_recip_reg <= dth_pkg::SPAN_RECIP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dth_pkg::CFG_DEPTH_LO:   depth_lo_reg   <= cfg_data[DEPTH_BITS-1:0];
                dth_pkg::CFG_DEPTH_HI:   depth_hi_reg   <= cfg_data[DEPTH_BITS-1:0];
                dth_pkg::CFG_SPAN_RECIP: span_recip_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage control
    logic [NS:1]       vld_reg;
    logic [NS:1]       en;
    dth_pkg::ctl_t     ctl_reg [1:NS-1];
    dth_pkg::ctl_t     ctl_next [1:NS-1];

    always_comb
    begin
        en[NS] = !vld_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // datapath registers
    logic [DEPTH_BITS-1:0]    diff1_reg;
    logic [PROD_W-1:0]        prod2_reg;
    logic [F-1:0]             frac3_reg;
    logic [Y_W-1:0]           y4_reg;
    logic [dth_pkg::LVL_W-1:0] t5_reg;
    logic [dth_pkg::DIV_W-1:0] q6_reg;
    logic [31:0]              rgba_reg;
    logic                     last_reg;

    logic [DEPTH_BITS-1:0]    depth_in;
    logic [NORM_W-1:0]        norm_wide;
    logic [F+2:0]             hue3;
    logic                     sat3;
    logic [dth_pkg::LVL_W-1:0] fl5;
    logic [dth_pkg::LVL_W-1:0] ce5;
    logic [dth_pkg::LVL_W-1:0] t5_next;
    logic [7:0]               mid7;
    logic [7:0]               r7, g7, b7;
    logic [31:0]              rgba_next;

    assign depth_in  = s_tdata[DEPTH_BITS-1:0];
    assign norm_wide = prod2_reg[PROD_W-1 -: NORM_W];
    assign sat3      = |norm_wide[NORM_W-1:F];
    assign hue3      = ({3'b000, norm_wide[F-1:0]} << 2) + ({3'b000, norm_wide[F-1:0]} << 1);

    assign fl5 = y4_reg[Y_W-1:F];
    assign ce5 = fl5 + dth_pkg::LVL_W'(|y4_reg[F-1:0]);
    assign t5_next = ctl_reg[4].sext[0] ? (dth_pkg::MID2_BASE - ce5)
                                        : (dth_pkg::MID1_BASE + fl5);

    assign mid7 = q6_reg[dth_pkg::DIV_SHIFT +: 8];

    always_comb
    begin
        ctl_next[1].last  = s_tlast;
        ctl_next[1].below = depth_in < depth_lo_reg;
        ctl_next[1].black = depth_in > depth_hi_reg;
        ctl_next[1].sext  = dth_pkg::SEXT_0;
        for (int k = 2; k <= NS - 1; k++)
        begin
            ctl_next[k] = ctl_reg[k-1];
        end
        ctl_next[3].black = ctl_reg[2].black || sat3;
        ctl_next[3].sext  = hue3[F+2:F];
    end

    always_comb
    begin
        unique case (ctl_reg[6].sext)
            dth_pkg::SEXT_0: begin r7 = dth_pkg::LVL_V_BYTE; g7 = mid7; b7 = dth_pkg::LVL_M_BYTE; end
            dth_pkg::SEXT_1: begin r7 = mid7; g7 = dth_pkg::LVL_V_BYTE; b7 = dth_pkg::LVL_M_BYTE; end
            dth_pkg::SEXT_2: begin r7 = dth_pkg::LVL_M_BYTE; g7 = dth_pkg::LVL_V_BYTE; b7 = mid7; end
            dth_pkg::SEXT_3: begin r7 = dth_pkg::LVL_M_BYTE; g7 = mid7; b7 = dth_pkg::LVL_V_BYTE; end
            dth_pkg::SEXT_4: begin r7 = mid7; g7 = dth_pkg::LVL_M_BYTE; b7 = dth_pkg::LVL_V_BYTE; end
            dth_pkg::SEXT_5: begin r7 = dth_pkg::LVL_V_BYTE; g7 = dth_pkg::LVL_M_BYTE; b7 = mid7; end
            default:         begin r7 = '0; g7 = '0; b7 = '0; end
        endcase

        priority if (ctl_reg[6].below)
        begin
            rgba_next = dth_pkg::RGBA_WHITE;
        end
        else if (ctl_reg[6].black)
        begin
            rgba_next = dth_pkg::RGBA_BLACK;
        end
        else
        begin
            rgba_next = {dth_pkg::ALPHA_OPAQUE, b7, g7, r7};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            diff1_reg  <= depth_in - depth_lo_reg;
            ctl_reg[1] <= ctl_next[1];
        end
        if (en[2])
        begin
            prod2_reg  <= PROD_W'(diff1_reg) * PROD_W'(span_recip_reg);
            ctl_reg[2] <= ctl_next[2];
        end
        if (en[3])
        begin
            frac3_reg  <= hue3[F-1:0];
            ctl_reg[3] <= ctl_next[3];
        end
        if (en[4])
        begin
            y4_reg     <= Y_W'(frac3_reg) * Y_W'(dth_pkg::MID_SLOPE);
            ctl_reg[4] <= ctl_next[4];
        end
        if (en[5])
        begin
            t5_reg     <= t5_next;
            ctl_reg[5] <= ctl_next[5];
        end
        if (en[6])
        begin
            q6_reg     <= dth_pkg::DIV_W'(t5_reg) * dth_pkg::DIV_W'(dth_pkg::DIV_RECIP);
            ctl_reg[6] <= ctl_next[6];
        end
        if (en[7])
        begin
            rgba_reg <= rgba_next;
            last_reg <= ctl_reg[6].last;
        end
    end

    assign m_tvalid = vld_reg[NS];
    assign m_tdata  = rgba_reg;
    assign m_tlast  = last_reg;

    // checks
    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] == dth_pkg::ALPHA_OPAQUE)
        else $error("alpha byte not opaque");

    a_ramp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata != dth_pkg::RGBA_WHITE && m_tdata != dth_pkg::RGBA_BLACK)
        |-> (m_tdata[7:0] >= dth_pkg::LVL_M_BYTE && m_tdata[7:0] <= dth_pkg::LVL_V_BYTE))
        else $error("red channel outside ramp levels");

    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> &vld_reg)
        else $error("input held back with a free stage");

    a_out_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en[NS] |=> vld_reg[NS] == $past(vld_reg[NS-1]))
        else $error("output stage lost or invented a word");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for depth_to_hue_colour. A directed table covers reset
// defaults, range edges, every hue sextant, full scale, an inconsistent
// scale, min above max and the unused register index. Random register
// settings and depth streams follow, with random idling on both stream sides.
// Every output word is checked against its table colour or the hue ramp predictor.
// ============================================================================

module tb;

    localparam int FRAC         = dth_pkg::FRACTION_BITS_DEF;
    localparam int IDX_W        = dth_pkg::CFG_IDX_W;
    localparam int PIPE_LATENCY = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_WORDS  = 50;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [63:0] ONE_F   = 64'd1 << FRAC;
    localparam logic [63:0] LVL_V   = 64'd30000 << FRAC;
    localparam logic [63:0] LVL_M   = 64'd10000 << FRAC;
    localparam logic [63:0] LVL_DEN = 64'd40000 << FRAC;
    localparam logic [31:0] RGBA_AT_MIN = 32'hFF3F_3FBF;   // v, m, m
    localparam logic [31:0] WHITE   = dth_pkg::RGBA_WHITE;
    localparam logic [31:0] BLACK   = dth_pkg::RGBA_BLACK;

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;
    typedef enum logic [2:0] {MODE_FULL, MODE_NARROW, MODE_WIDE, MODE_WILD,
                              MODE_INVERTED} cfg_mode_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      value;   // register data, or depth in low bits
        logic             last;
        logic             known;
        logic [31:0]      rgba;
    } dir_row_t;

    typedef struct packed {
        logic [31:0] rgba;
        logic        last;
    } pixel_t;

    localparam int DIR_ROWS = 31;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd0,          1'b0, 1'b1, RGBA_AT_MIN},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd65535,      1'b1, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd32768,      1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'h0000_AAAA,  1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'h0000_5555,  1'b1, 1'b0, 32'd0},
        '{ROW_CFG, dth_pkg::CFG_DEPTH_LO,   32'hFFFF_03E8,  1'b0, 1'b0, 32'd0},
        '{ROW_CFG, dth_pkg::CFG_DEPTH_HI,   32'h0001_07D0,  1'b0, 1'b0, 32'd0},
        '{ROW_CFG, dth_pkg::CFG_SPAN_RECIP, 32'd4294967,    1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd999,        1'b1, 1'b1, WHITE},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1000,       1'b0, 1'b1, RGBA_AT_MIN},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1100,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1250,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1400,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1500,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1600,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1750,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1900,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd2000,       1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd2001,       1'b1, 1'b1, BLACK},
        '{ROW_CFG, dth_pkg::CFG_SPAN_RECIP, 32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd2000,       1'b1, 1'b1, BLACK},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1000,       1'b0, 1'b1, RGBA_AT_MIN},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1001,       1'b0, 1'b0, 32'd0},
        '{ROW_CFG, CFG_UNUSED,              32'h0000_0000,  1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd1000,       1'b0, 1'b1, RGBA_AT_MIN},
        '{ROW_CFG, dth_pkg::CFG_DEPTH_LO,   32'd5000,       1'b0, 1'b0, 32'd0},
        '{ROW_CFG, dth_pkg::CFG_DEPTH_HI,   32'd100,        1'b0, 1'b0, 32'd0},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd4999,       1'b0, 1'b1, WHITE},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd5000,       1'b0, 1'b1, BLACK},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd65535,      1'b1, 1'b1, BLACK},
        '{ROW_PIX, dth_pkg::CFG_DEPTH_LO,   32'd0,          1'b0, 1'b1, WHITE}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = dth_pkg::CFG_DEPTH_LO;
    logic [31:0]          cfg_data  = 32'd0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = 16'd0;   // [15:0] depth
    logic                 s_tlast   = 1'b0;    // frame_end
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;             // [31:0] rgba
    logic                 m_tlast;             // frame_end_out

    logic [15:0] cfg_min   = 16'(dth_pkg::DEPTH_LO_RST);
    logic [15:0] cfg_max   = 16'(dth_pkg::DEPTH_HI_RST);
    logic [31:0] cfg_scale = dth_pkg::SPAN_RECIP_RST;

    pixel_t expected_pixels [$];
    pixel_t head_px;
    int     mismatches  = 0;
    int     idle_cycles = 0;
    int     sink_hold   = 0;
    logic   pipe_busy   = 1'b0;
    logic   quiet       = 1'b0;

    depth_to_hue_colour DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] level_byte(input logic [63:0] lvl);
        return 8'((64'd255 * lvl) / LVL_DEN);
    endfunction

    function automatic logic [31:0] hue_ramp(input logic [15:0] depth);
        logic [63:0] norm;
        logic [63:0] h;
        logic [63:0] frac;
        logic [63:0] ramp_up;
        logic [63:0] ramp_dn;
        logic [63:0] lr;
        logic [63:0] lg;
        logic [63:0] lb;
        if (depth < cfg_min)
            return WHITE;
        if (depth > cfg_max)
            return BLACK;
        norm = ((64'(depth) - 64'(cfg_min)) * 64'(cfg_scale)) >> (32 - FRAC);
        if (norm > ONE_F)
            norm = ONE_F;
        h       = norm * 64'd6;
        frac    = h & (ONE_F - 64'd1);
        ramp_up = LVL_M + 64'd20001 * frac;
        ramp_dn = LVL_V - 64'd20001 * frac;
        case (3'(h >> FRAC))
            dth_pkg::SEXT_0: {lr, lg, lb} = {LVL_V, ramp_up, LVL_M};
            dth_pkg::SEXT_1: {lr, lg, lb} = {ramp_dn, LVL_V, LVL_M};
            dth_pkg::SEXT_2: {lr, lg, lb} = {LVL_M, LVL_V, ramp_up};
            dth_pkg::SEXT_3: {lr, lg, lb} = {LVL_M, ramp_dn, LVL_V};
            dth_pkg::SEXT_4: {lr, lg, lb} = {ramp_up, LVL_M, LVL_V};
            dth_pkg::SEXT_5: {lr, lg, lb} = {LVL_V, LVL_M, ramp_dn};
            default:         return BLACK;
        endcase
        return {dth_pkg::ALPHA_OPAQUE, level_byte(lb), level_byte(lg), level_byte(lr)};
    endfunction

    // empty the pipeline before touching registers
    task automatic drain_pipe();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1)
            @(posedge clk);
        pipe_busy = 1'b0;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        if (pipe_busy)
            drain_pipe();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            dth_pkg::CFG_DEPTH_LO:   cfg_min   = value[15:0];
            dth_pkg::CFG_DEPTH_HI:   cfg_max   = value[15:0];
            dth_pkg::CFG_SPAN_RECIP: cfg_scale = value;
            default:                 ;
        endcase
    endtask

    task automatic send_pixel(input logic [15:0] depth, input logic last,
                              input logic known, input logic [31:0] rgba);
        pixel_t px;
        cfg_valid <= 1'b0;
        s_tvalid  <= 1'b1;
        s_tdata   <= depth;
        s_tlast   <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        px.rgba = known ? rgba : hue_ramp(depth);
        px.last = last;
        expected_pixels.push_back(px);
        pipe_busy = 1'b1;
    endtask

    initial
    begin
        cfg_mode_t   mode;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] depth;
        logic [15:0] rim_depths [4];
        logic [63:0] span_scale;
        int          pick;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            else
                send_pixel(directed_rows[i].value[15:0], directed_rows[i].last,
                           directed_rows[i].known, directed_rows[i].rgba);

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            mode       = cfg_mode_t'($urandom_range(0, 4));
            lo         = 16'($urandom);
            hi         = 16'($urandom);
            span_scale = 64'($urandom);
            case (mode)
                MODE_FULL:
                begin
                    lo = 16'd0;
                    hi = 16'hFFFF;
                end
                MODE_NARROW:
                begin
                    lo = 16'($urandom_range(0, 65531));
                    hi = lo + 16'($urandom_range(1, 4));
                end
                MODE_WIDE:
                begin
                    lo = 16'($urandom_range(0, 65534));
                    hi = 16'($urandom_range(32'(lo) + 1, 65535));
                end
                MODE_WILD:
                begin
                    if ($urandom_range(0, 3) == 0)
                        hi = lo;
                end
                default:
                begin
                    lo = 16'($urandom_range(1, 65535));
                    hi = 16'($urandom_range(0, 32'(lo) - 1));
                end
            endcase
            if (mode == MODE_FULL || mode == MODE_NARROW || mode == MODE_WIDE)
            begin
                span_scale = (64'd1 << 32) / (64'(hi) - 64'(lo));
                if (span_scale > 64'hFFFF_FFFF)
                    span_scale = 64'hFFFF_FFFF;
            end

            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_UNUSED, $urandom);
            write_reg(dth_pkg::CFG_DEPTH_LO, {16'($urandom), lo});
            write_reg(dth_pkg::CFG_DEPTH_HI, {16'($urandom), hi});
            write_reg(dth_pkg::CFG_SPAN_RECIP, span_scale[31:0]);

            quiet      = (phase == RAND_PHASES - 1);
            rim_depths = '{lo - 16'd1, lo, hi, hi + 16'd1};

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    depth = 16'($urandom_range(32'(hi), 32'(lo)));
                else if (pick < 8)
                    depth = rim_depths[$urandom_range(0, 3)];
                else
                    depth = 16'($urandom);
                send_pixel(depth, $urandom_range(0, 7) == 0, 1'b0, 32'd0);
                if (!quiet && $urandom_range(0, 3) == 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 5))
                        @(posedge clk);
                end
            end
        end

        drain_pipe();
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // output side back pressure in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (sink_hold != 0)
        begin
            m_tready <= 1'b0;
            sink_hold--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            sink_hold = $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, actual rgba %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                head_px = expected_pixels.pop_front();
                if (m_tdata !== head_px.rgba)
                begin
                    $display("%0t: rgba mismatch, expected %h, actual %h",
                             $time, head_px.rgba, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== head_px.last)
                begin
                    $display("%0t: frame end mismatch, expected %b, actual %b",
                             $time, head_px.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles without any word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

endmodule

FILE: files.f
rtl/core/dth_pkg.sv
rtl/core/depth_to_hue_colour.sv
verif/tb.sv
